// File: hw/rtl/lrupr_pkg.sv
// Shared widths and defaults for the LRU page replacement core.
`default_nettype none

package lrupr_pkg;

   localparam int PAGE_W             = 8;
   localparam int FRAME_W            = 9;
   localparam int FAULT_W            = 32;
   localparam int PAGES_DEFAULT      = 256;
   localparam int STAMP_BITS_DEFAULT = 32;

   localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd4;

endpackage

`default_nettype wire

// File: hw/rtl/lrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lrupr_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lru_page_replacement_core.sv
// Top level of the counter-timestamp LRU page replacement core.
`default_nettype none

// Each accepted word is one page reference. A single RAM holds, per page, a
// resident bit and the last-use stamp. A hit or a fault that still finds a
// free frame shows its result on rsp_strobe after the lookup state and the
// result register; busy is already low in that strobe cycle, so the next
// word can be taken in it. A fault with no free frame scans every page
// entry through the one RAM read port and a single stamp comparator, one
// entry per cycle, so its result shows after the lookup, scan, drain and
// eviction states and the result register. Results are shown for exactly
// one cycle and the receiver cannot stall; a new word may be started during
// the strobe cycle. After reset the core runs a clearing pass over all PAGES
// entries (busy high); configuration writes are still taken meanwhile. A
// write of the frame count reloads the free-frame counter and leaves
// resident pages in place.
module lru_page_replacement_core
   import lrupr_pkg::*;
#(
   parameter int PAGES      = PAGES_DEFAULT,
   parameter int STAMP_BITS = STAMP_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request side
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [PAGE_W-1:0]  req_page,
   // result side
   output logic                    rsp_strobe,
   output logic                    rsp_is_fault,
   output logic                    rsp_evict_valid,
   output logic [PAGE_W-1:0]       rsp_evicted_page,
   output logic [FAULT_W-1:0]      rsp_fault_total,
   output logic                    rsp_stamp_overflow,
   // frame count register
   input  wire logic               csr_wr_en,
   input  wire logic [FRAME_W-1:0] csr_wr_data
);

   localparam int IDX_W   = $clog2(PAGES);
   localparam int REM_W   = IDX_W + 1;
   localparam int ENTRY_W = STAMP_BITS + 1;

   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(PAGES - 1);
   localparam logic [REM_W-1:0]      PAGES_REM = REM_W'(PAGES);
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
   localparam logic [FAULT_W-1:0]    FAULT_MAX = '1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_DRAIN,
      ST_EVICT
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       pg_ff, pg_in;
   logic [FRAME_W-1:0]     free_left_ff, free_left_in;
   logic [STAMP_BITS-1:0]  stamp_ff, stamp_in;
   logic [FAULT_W-1:0]     fault_ff, fault_in;
   // scan pipeline: the entry on rd_data belongs to scan_idx_ff
   logic                   scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       victim_ff, victim_in;
   logic [STAMP_BITS-1:0]  best_ff, best_in;
   // registered result
   logic                   strobe_ff, strobe_in;
   logic                   is_fault_ff, is_fault_in;
   logic                   evict_ff, evict_in;
   logic [PAGE_W-1:0]      evicted_ff, evicted_in;
   logic [FAULT_W-1:0]     total_ff, total_in;
   logic                   ovf_ff, ovf_in;

   // RAM port
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [ENTRY_W-1:0]     ram_wr_data;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]     ram_rd_data;

   logic                   rd_present;
   logic [STAMP_BITS-1:0]  rd_stamp;
   logic                   older;
   logic                   take;
   logic [STAMP_BITS-1:0]  stamp_next;
   logic [REM_W-1:0]       rem;
   logic [IDX_W-1:0]       req_idx;
   logic [IDX_W+PAGE_W-1:0] victim_ext;

   // page number modulo PAGES, restoring style, one input bit a step
   always_comb begin
      rem = '0;
      for (int b = PAGE_W - 1; b >= 0; b--) begin
         rem = {rem[REM_W-2:0], req_page[b]};
         if (rem >= PAGES_REM) begin
            rem = rem - PAGES_REM;
         end
      end
      req_idx = rem[IDX_W-1:0];
   end

   assign rd_present = ram_rd_data[STAMP_BITS];
   assign rd_stamp   = ram_rd_data[STAMP_BITS-1:0];

   // the one shared comparator; strict less-than keeps the lowest page on ties
   assign older = rd_stamp < best_ff;
   assign take  = scan_vld_ff && rd_present && (!found_ff || older);

   assign stamp_next = (stamp_ff != STAMP_MAX) ? stamp_ff + 1'b1 : stamp_ff;
   assign victim_ext = {{PAGE_W{1'b0}}, victim_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pg_in        = pg_ff;
      free_left_in = free_left_ff;
      stamp_in     = stamp_ff;
      fault_in     = fault_ff;
      scan_vld_in  = 1'b0;
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      strobe_in    = 1'b0;
      is_fault_in  = is_fault_ff;
      evict_in     = evict_ff;
      evicted_in   = evicted_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pg_ff;
      ram_wr_data  = {1'b1, stamp_ff};
      ram_rd_addr  = cnt_ff;

      if (take) begin
         found_in  = 1'b1;
         victim_in = scan_idx_ff;
         best_in   = rd_stamp;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = '0;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_rd_addr = req_idx;
            if (start) begin
               pg_in    = req_idx;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (rd_present) begin
               // hit: refresh stamp and answer
               ram_wr_en   = 1'b1;
               stamp_in    = stamp_next;
               strobe_in   = 1'b1;
               is_fault_in = 1'b0;
               evict_in    = 1'b0;
               evicted_in  = '0;
               total_in    = fault_ff;
               ovf_in      = (stamp_next == STAMP_MAX);
               state_in    = ST_IDLE;
            end else begin
               fault_in = (fault_ff != FAULT_MAX) ? fault_ff + 1'b1 : fault_ff;
               if (free_left_ff != '0) begin
                  free_left_in = free_left_ff - 1'b1;
                  ram_wr_en    = 1'b1;
                  stamp_in     = stamp_next;
                  strobe_in    = 1'b1;
                  is_fault_in  = 1'b1;
                  evict_in     = 1'b0;
                  evicted_in   = '0;
                  total_in     = fault_in;
                  ovf_in       = (stamp_next == STAMP_MAX);
                  state_in     = ST_IDLE;
               end else begin
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ram_rd_addr = cnt_ff;
            scan_vld_in = 1'b1;
            scan_idx_in = cnt_ff;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // all reads issued; the new page is not resident, so place it now
            ram_wr_en = 1'b1;
            state_in  = ST_EVICT;
         end
         ST_EVICT: begin
            ram_wr_en   = found_ff;
            ram_wr_addr = victim_ff;
            ram_wr_data = '0;
            stamp_in    = stamp_next;
            strobe_in   = 1'b1;
            is_fault_in = 1'b1;
            evict_in    = found_ff;
            evicted_in  = found_ff ? victim_ext[PAGE_W-1:0] : '0;
            total_in    = fault_ff;
            ovf_in      = (stamp_next == STAMP_MAX);
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // frame count write reloads the free-frame counter
      if (csr_wr_en) begin
         free_left_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         free_left_ff <= FRAME_RESET;
         stamp_ff     <= '0;
         fault_ff     <= '0;
         scan_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         free_left_ff <= free_left_in;
         stamp_ff     <= stamp_in;
         fault_ff     <= fault_in;
         scan_vld_ff  <= scan_vld_in;
         found_ff     <= found_in;
         strobe_ff    <= strobe_in;
      end
      pg_ff       <= pg_in;
      scan_idx_ff <= scan_idx_in;
      victim_ff   <= victim_in;
      best_ff     <= best_in;
      is_fault_ff <= is_fault_in;
      evict_ff    <= evict_in;
      evicted_ff  <= evicted_in;
      total_ff    <= total_in;
      ovf_ff      <= ovf_in;
   end

   lrupr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAGES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_is_fault       = is_fault_ff;
   assign rsp_evict_valid    = evict_ff;
   assign rsp_evicted_page   = evicted_ff;
   assign rsp_fault_total    = total_ff;
   assign rsp_stamp_overflow = ovf_ff;

`ifndef SYNTHESIS
   // a word only comes out of a lookup or an eviction step
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_EVICT))
      else $error("result strobe without lookup or eviction");

   // an eviction is always a fault
   a_evict_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_evict_valid |-> rsp_is_fault)
      else $error("eviction reported on a hit");

   // an accepted word makes the core busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("core not busy after accept");

   // free frames only shrink, except by a register write
   a_free_monotonic: assert property (@(posedge clock) disable iff (reset)
      !csr_wr_en |=> free_left_ff <= $past(free_left_ff))
      else $error("free frame count grew without a write");
`endif

endmodule

`default_nettype wire
